>>> sv/epd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epd_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned ChunkW  = 5;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IdxW    = 3;

  localparam logic [ChW-1:0] CharLo   = 8'd63;
  localparam logic [ChW-1:0] CharHi   = 8'd126;
  localparam int unsigned    ContBit  = 5;

  // short queue between classifier and executor
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_CONT = 2'd0,  // chunk, value continues
    OP_FIN  = 2'd1,  // last chunk of a value
    OP_END  = 2'd2   // string terminator
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ChunkW-1:0] chunk;
  } op_t;

endpackage

`default_nettype wire

>>> sv/epd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface epd_in_if;
  logic                    valid;
  logic                    ready;
  logic [epd_pkg::ChW-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface epd_out_if;
  logic                                valid;
  logic                                ready;
  epd_pkg::kind_e                      kind;
  logic signed [epd_pkg::CoordW-1:0]   lat;
  logic signed [epd_pkg::CoordW-1:0]   lng;
  logic        [epd_pkg::CountW-1:0]   point_count;

  modport source (output valid, output kind, output lat, output lng, output point_count,
                  input ready);
  modport sink   (input valid, input kind, input lat, input lng, input point_count,
                  output ready);
endinterface

`default_nettype wire

>>> sv/epd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module epd_front (
  epd_in_if.sink          in_i,
  output logic            op_valid_o,
  output epd_pkg::op_t    op_o,
  input  logic            op_ready_i
);
  import epd_pkg::*;

  logic [ChW-1:0] bits;
  logic           in_range;

  assign in_range = (in_i.ch >= CharLo) && (in_i.ch <= CharHi);
  assign bits     = in_i.ch - CharLo;

  always_comb begin
    op_o.chunk = bits[ChunkW-1:0];
    if (!in_range) begin
      op_o.op = OP_END;
    end else if (bits[ContBit]) begin
      op_o.op = OP_CONT;
    end else begin
      op_o.op = OP_FIN;
    end
  end

  assign op_valid_o = in_i.valid;
  assign in_i.ready = op_ready_i;

endmodule

`default_nettype wire

>>> sv/epd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module epd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  epd_pkg::op_t  push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output epd_pkg::op_t  pop_data_o,
  output logic          empty_o,
  output logic [epd_pkg::QCntW-1:0] count_o
);
  import epd_pkg::*;

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign count_o    = cnt_q;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (p == QPtrW'(QDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/epd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module epd_back #(
  parameter int unsigned MAX_CHUNKS = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  input  epd_pkg::op_t  op_i,
  output logic          op_pop_o,
  epd_out_if.source     out_o
);
  import epd_pkg::*;

  logic [CoordW-1:0] chunk_acc_q, chunk_acc_d;
  logic [IdxW-1:0]   chunk_index_q, chunk_index_d;
  logic              expect_lng_q, expect_lng_d;
  logic [CoordW-1:0] run_lat_q, run_lat_d;
  logic [CoordW-1:0] run_lng_q, run_lng_d;
  logic [CountW-1:0] points_q, points_d;
  logic              overlong_q, overlong_d;

  logic              out_valid_q, out_valid_d;
  kind_e             out_kind_q, out_kind_d;
  logic [CoordW-1:0] out_lat_q, out_lat_d;
  logic [CoordW-1:0] out_lng_q, out_lng_d;
  logic [CountW-1:0] out_cnt_q, out_cnt_d;

  logic              needs_out, out_free, fire;
  logic              at_limit;
  logic [4:0]        shamt;
  logic [CoordW-1:0] acc_new;
  logic [CoordW-1:0] delta;
  logic              bad;

  assign at_limit  = (chunk_index_q >= IdxW'(MAX_CHUNKS));
  assign shamt     = {chunk_index_q, 2'b00} + 5'(chunk_index_q);   // 5 * index
  assign acc_new   = at_limit ? chunk_acc_q
                              : (chunk_acc_q | (CoordW'(op_i.chunk) << shamt));
  // zigzag decode
  assign delta     = acc_new[0] ? ~(acc_new >> 1) : (acc_new >> 1);
  assign bad       = (chunk_index_q != '0) || (chunk_acc_q != '0) ||
                     expect_lng_q || overlong_q;

  assign needs_out = (op_i.op == OP_END) || ((op_i.op == OP_FIN) && expect_lng_q);
  assign out_free  = !out_valid_q || out_o.ready;
  assign fire      = op_valid_i && (!needs_out || out_free);
  assign op_pop_o  = fire;

  always_comb begin
    chunk_acc_d   = chunk_acc_q;
    chunk_index_d = chunk_index_q;
    expect_lng_d  = expect_lng_q;
    run_lat_d     = run_lat_q;
    run_lng_d     = run_lng_q;
    points_d      = points_q;
    overlong_d    = overlong_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_kind_d    = out_kind_q;
    out_lat_d     = out_lat_q;
    out_lng_d     = out_lng_q;
    out_cnt_d     = out_cnt_q;

    if (fire) begin
      case (op_i.op)
        OP_END: begin
          out_valid_d   = 1'b1;
          out_kind_d    = bad ? KIND_ERR : KIND_OK;
          out_lat_d     = run_lat_q;
          out_lng_d     = run_lng_q;
          out_cnt_d     = points_q;
          chunk_acc_d   = '0;
          chunk_index_d = '0;
          expect_lng_d  = 1'b0;
          run_lat_d     = '0;
          run_lng_d     = '0;
          points_d      = '0;
          overlong_d    = 1'b0;
        end
        OP_CONT: begin
          chunk_acc_d = acc_new;
          if (at_limit) begin
            overlong_d = 1'b1;
          end else begin
            chunk_index_d = chunk_index_q + 1'b1;
          end
        end
        OP_FIN: begin
          if (at_limit) begin
            overlong_d = 1'b1;
          end
          chunk_acc_d   = '0;
          chunk_index_d = '0;
          if (!expect_lng_q) begin
            run_lat_d    = run_lat_q + delta;
            expect_lng_d = 1'b1;
          end else begin
            run_lng_d    = run_lng_q + delta;
            expect_lng_d = 1'b0;
            points_d     = (points_q != '1) ? points_q + 1'b1 : points_q;
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_POINT;
            out_lat_d    = run_lat_q;
            out_lng_d    = run_lng_q + delta;
            out_cnt_d    = (points_q != '1) ? points_q + 1'b1 : points_q;
          end
        end
        default: begin
          chunk_acc_d = chunk_acc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_acc_q   <= '0;
      chunk_index_q <= '0;
      expect_lng_q  <= 1'b0;
      run_lat_q     <= '0;
      run_lng_q     <= '0;
      points_q      <= '0;
      overlong_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      chunk_acc_q   <= chunk_acc_d;
      chunk_index_q <= chunk_index_d;
      expect_lng_q  <= expect_lng_d;
      run_lat_q     <= run_lat_d;
      run_lng_q     <= run_lng_d;
      points_q      <= points_d;
      overlong_q    <= overlong_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_lat_q  <= out_lat_d;
    out_lng_q  <= out_lng_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.lat         = out_lat_q;
  assign out_o.lng         = out_lng_q;
  assign out_o.point_count = out_cnt_q;

endmodule

`default_nettype wire

>>> sv/encoded_polyline_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Encoded polyline decoder. Takes one character per cycle on in_i and emits
// a point (kind 0) after every finished longitude and an end item (kind 1 ok,
// kind 2 error) on a terminator: a zero byte or any byte outside 63..126.
// Coordinates are running sums in 1e-5 degree units and wrap at 32 bits.
// Throughput is one character per cycle unless out_o is held; the shift, OR
// and 32-bit add in the executor are combinational; data is registered in the
// queue and the output register. A two-entry queue sits between the classifier
// and the executor, and the output register lets the next character be taken
// while a result waits; input stalls only when the output is held long
// enough to fill the queue. MAX_CHUNKS (6 or 7) caps the chunks per value.
module encoded_polyline_decoder_top #(
  parameter int unsigned MAX_CHUNKS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  epd_in_if.sink     in_i,
  epd_out_if.source  out_o
);
  import epd_pkg::*;

  op_t              fr_op;
  logic             fr_valid;
  logic             q_full, q_empty, q_pop;
  op_t              q_head;
  logic [QCntW-1:0] q_count;

  epd_front u_front (
    .in_i       (in_i),
    .op_valid_o (fr_valid),
    .op_o       (fr_op),
    .op_ready_i (!q_full)
  );

  epd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fr_valid),
    .push_data_i (fr_op),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_head),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  epd_back #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (!q_empty),
    .op_i       (q_head),
    .op_pop_o   (q_pop),
    .out_o      (out_o)
  );

  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QDepth))
    else $error("queue count exceeds depth");

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("executor popped an empty queue");

  a_point_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == KIND_POINT) |-> out_o.point_count != '0)
    else $error("point item with zero count");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !q_pop) |=> !q_empty)
    else $error("accepted item missing from queue");

endmodule

`default_nettype wire
